[rtl/core/vss_pkg.sv]
package vss_pkg;

  localparam int unsigned NumVenues = 8;
  localparam int unsigned IdxW      = 3;
  localparam int unsigned ScoreW    = 23;

  typedef enum logic [1:0] {
    ModeWrite = 2'd0,
    ModeBest  = 2'd1,
    ModeTop   = 2'd2,
    ModeNone  = 2'd3
  } mode_e;

  // Stored venue entry.
  typedef struct packed {
    logic        enabled;
    logic        internal_liq;
    logic [30:0] size_limit;
    logic [6:0]  prio;
    logic [19:0] latency;
    logic [19:0] fill;
    logic [19:0] fee;
  } entry_t;

  // Request passed from the front end to the back end.
  typedef struct packed {
    mode_e       mode;
    logic [2:0]  index;
    entry_t      entry;
    logic [31:0] quantity;
    logic [3:0]  max_venues;
  } req_t;

  localparam int unsigned EntryW = $bits(entry_t);
  localparam int unsigned ReqW   = $bits(req_t);

endpackage

[rtl/core/venue_score_selector.sv]
// Venue selector: a request in mode 0 writes one venue entry and gives no
// result; mode 1 returns the best qualifying venue (found=0 when none); mode 2
// returns up to max_venues venues in descending score, last on the final one.
// The mode travels on s_axis_tuser. A selection scores the entries one by one
// through a single scorer, each venue passing the read, score, fee and sum
// states; after the first result, further results follow one a cycle while
// m_axis_tready is high. The back end takes its next request in the cycle
// after the last result goes out; a write leaves it idle. A two-entry queue
// sits in front of the scorer.
module venue_score_selector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // venue_index[2:0], venue_enabled[3], venue_internal[4],
  // max_order_size[35:5], priority_req[42:36], latency_ns[62:43],
  // fill_rate[82:63], fee_per_share[102:83], quantity[134:103],
  // max_venues[138:135], zero fill to 144
  input  logic [143:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // chosen_venue[2:0], found[3], venue_score[26:4], zero fill to 32
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  vss_pkg::req_t in_req, q_req;
  logic q_valid, q_ready;
  logic [2:0]  chosen;
  logic        found;
  logic [22:0] score;

  always_comb begin
    in_req.mode  = vss_pkg::mode_e'(s_axis_tuser);
    in_req.index = s_axis_tdata[2:0];
    in_req.entry.enabled      = s_axis_tdata[3];
    in_req.entry.internal_liq = s_axis_tdata[4];
    in_req.entry.size_limit   = s_axis_tdata[35:5];
    in_req.entry.prio         = s_axis_tdata[42:36];
    in_req.entry.latency      = s_axis_tdata[62:43];
    in_req.entry.fill         = s_axis_tdata[82:63];
    in_req.entry.fee          = s_axis_tdata[102:83];
    in_req.quantity   = s_axis_tdata[134:103];
    in_req.max_venues = s_axis_tdata[138:135];
  end

  vss_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_req_i   (in_req),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_req_o    (q_req)
  );

  vss_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_req_i     (q_req),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .chosen_o    (chosen),
    .found_o     (found),
    .score_o     (score),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, score, found, chosen};

endmodule

[rtl/core/vss_ram.sv]
module vss_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/vss_front.sv]
// Two-entry request queue; drops unused mode codes.
module vss_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vss_pkg::req_t     in_req_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output vss_pkg::req_t     q_req_o
);

  vss_pkg::req_t slot_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, wr_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o && (in_req_i.mode != vss_pkg::ModeNone);
  assign pop  = q_valid_o && q_ready_i;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_req_o = slot_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (!push && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= in_req_i;
  end

endmodule

[rtl/core/vss_back.sv]
// Scores the table one entry at a time through the read, score, fee and sum
// states, then emits picks by repeated max search over the registered scores.
module vss_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  output logic                        q_ready_o,
  input  vss_pkg::req_t               q_req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [vss_pkg::IdxW-1:0]    chosen_o,
  output logic                        found_o,
  output logic [vss_pkg::ScoreW-1:0]  score_o,
  output logic                        last_o
);

  typedef enum logic [2:0] {
    StIdle, StRead, StScore, StFee, StSum, StPick, StOut
  } state_e;

  state_e state_q;
  vss_pkg::req_t req_q;
  logic [vss_pkg::NumVenues-1:0] valid_q, ok_q;
  logic [vss_pkg::ScoreW-1:0] sc_q [vss_pkg::NumVenues];
  logic [vss_pkg::IdxW-1:0] idx_q;
  logic [3:0] left_q;
  logic       best_mode_q;

  logic       we;
  vss_pkg::entry_t rd_entry;
  logic [vss_pkg::EntryW-1:0] rd_raw;

  assign we = q_valid_i && (state_q == StIdle) && (q_req_i.mode == vss_pkg::ModeWrite);

  vss_ram #(.Width(vss_pkg::EntryW), .Depth(vss_pkg::NumVenues)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (q_req_i.index),
    .wdata_i (q_req_i.entry),
    .raddr_i (idx_q),
    .rdata_o (rd_raw)
  );
  assign rd_entry = vss_pkg::entry_t'(rd_raw);

  // stage 1: terms
  logic [31:0] qty;
  logic        qpos, qual;
  logic [51:0] cost, cost_q;
  logic [21:0] t_prio, t_lat, t_fill, t_fee;
  logic [21:0] t_prio_q, t_lat_q, t_fill_q, t_fee_q;
  logic        qual_q, int_q;

  assign qty  = req_q.quantity;
  assign qpos = (qty != 32'd0) && !qty[31];
  assign qual = qpos && valid_q[idx_q] && rd_entry.enabled
                && (qty[30:0] <= rd_entry.size_limit);
  assign cost = 52'(rd_entry.fee) * 52'(qty);

  // constant divides as reciprocal multiplies, exact over the field ranges
  logic [16:0] lat_diff;
  logic [45:0] lat_prod;
  logic [52:0] fill_prod;
  logic [17:0] prio_frac;
  always_comb begin
    // prio * 2^17 / 5 = prio * 26214 + floor(2 * prio / 5)
    prio_frac = 18'({rd_entry.prio, 1'b0}) * 18'd205;
    t_prio    = 22'(rd_entry.prio) * 22'd26214 + 22'(prio_frac[17:10]);
    fill_prod = 53'(rd_entry.fill) * 53'd5629499535;
    t_fill    = 22'(fill_prod[52:32]);
    lat_diff  = 17'(20'd100000 - rd_entry.latency);
    lat_prod  = 46'(lat_diff) * 46'd274877907;
    t_lat     = (rd_entry.latency < 20'd100000) ? lat_prod[45:24] : 22'd0;
  end

  // stage 2: fee term, partial sum
  logic [23:0] fee_diff;
  logic [57:0] fee_prod;
  logic [24:0] base, base_q;
  always_comb begin
    fee_diff = 24'(52'd10000000 - cost_q);
    fee_prod = 58'(fee_diff) * 58'd9007199255;
    t_fee    = (cost_q < 52'd10000000) ? 22'(fee_prod[57:37]) : 22'd0;
    base     = 25'(t_prio_q) + 25'(t_lat_q) + 25'(t_fill_q) + 25'd327680;
  end

  // stage 3: sum, boost, saturate
  logic [24:0] sum;
  logic [48:0] fifth;
  logic [27:0] boosted;
  logic [24:0] fin;
  logic [vss_pkg::ScoreW-1:0] sat;
  always_comb begin
    sum     = base_q + 25'(t_fee_q);
    // sum * 6 / 5 = sum + floor(sum / 5)
    fifth   = 49'(sum) * 49'd13421773;
    boosted = 28'(sum) + 28'(fifth[48:26]);
    fin     = int_q ? 25'(boosted) : sum;
    sat     = (fin > 25'h7FFFFF) ? 23'h7FFFFF : fin[22:0];
  end

  // max search over registered scores
  logic [vss_pkg::IdxW-1:0] best;
  logic any;
  always_comb begin
    best = '0;
    any  = 1'b0;
    for (int i = 0; i < vss_pkg::NumVenues; i++) begin
      if (ok_q[i] && (!any || sc_q[i] > sc_q[best])) begin
        best = vss_pkg::IdxW'(i);
        any  = 1'b1;
      end
    end
  end

  logic [3:0] cnt;
  always_comb begin
    cnt = '0;
    for (int i = 0; i < vss_pkg::NumVenues; i++) cnt = cnt + 4'(ok_q[i]);
  end

  assign q_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      req_q       <= '0;
      valid_q     <= '0;
      ok_q        <= '0;
      idx_q       <= '0;
      left_q      <= '0;
      best_mode_q <= 1'b0;
      t_prio_q    <= '0;
      t_lat_q     <= '0;
      t_fill_q    <= '0;
      t_fee_q     <= '0;
      cost_q      <= '0;
      base_q      <= '0;
      qual_q      <= 1'b0;
      int_q       <= 1'b0;
      for (int i = 0; i < vss_pkg::NumVenues; i++) sc_q[i] <= '0;
      out_valid_o <= 1'b0;
      chosen_o    <= '0;
      found_o     <= 1'b0;
      score_o     <= '0;
      last_o      <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (q_valid_i) begin
            req_q <= q_req_i;
            if (q_req_i.mode == vss_pkg::ModeWrite) begin
              valid_q[q_req_i.index] <= 1'b1;
            end else begin
              idx_q <= '0;
              ok_q  <= '0;
              best_mode_q <= (q_req_i.mode == vss_pkg::ModeBest);
              state_q <= StRead;
            end
          end
        end
        StRead: state_q <= StScore;
        StScore: begin
          t_prio_q <= t_prio;
          t_lat_q  <= t_lat;
          t_fill_q <= t_fill;
          cost_q   <= cost;
          qual_q   <= qual;
          int_q    <= rd_entry.internal_liq;
          state_q  <= StFee;
        end
        StFee: begin
          t_fee_q <= t_fee;
          base_q  <= base;
          state_q <= StSum;
        end
        StSum: begin
          ok_q[idx_q] <= qual_q;
          sc_q[idx_q] <= sat;
          if (idx_q == vss_pkg::IdxW'(vss_pkg::NumVenues - 1)) begin
            state_q <= StPick;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= StRead;
          end
        end
        StPick: begin
          if (best_mode_q) begin
            left_q <= 4'd1;
          end else begin
            left_q <= (req_q.max_venues < cnt) ? req_q.max_venues : cnt;
            if (req_q.max_venues == 4'd0 || cnt == 4'd0) state_q <= StIdle;
          end
          if (best_mode_q || (req_q.max_venues != 4'd0 && cnt != 4'd0)) begin
            out_valid_o <= 1'b1;
            chosen_o    <= any ? best : '0;
            found_o     <= any;
            score_o     <= any ? sc_q[best] : '0;
            last_o      <= best_mode_q || (req_q.max_venues == 4'd1) || (cnt == 4'd1);
            ok_q[best]  <= 1'b0;
            state_q     <= StOut;
          end
        end
        StOut: begin
          if (out_ready_i) begin
            if (last_o) begin
              out_valid_o <= 1'b0;
              state_q     <= StIdle;
            end else begin
              left_q     <= left_q - 4'd1;
              chosen_o   <= best;
              found_o    <= 1'b1;
              score_o    <= sc_q[best];
              last_o     <= (left_q == 4'd2);
              ok_q[best] <= 1'b0;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

[rtl/core/vss_checker.sv]
module vss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_nofound_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[3] |-> m_axis_tlast && m_axis_tdata[26:4] == 23'd0)
    else $error("not-found result malformed");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[31:27] == 5'd0)
    else $error("pad bits set");

endmodule

bind venue_score_selector vss_checker u_vss_checker (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);
